>>> rtl/bse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary search engine package
// Shared widths, defaults and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int LEN_W           = 11;   // table_length register width
    localparam int IDX_W           = 10;   // entry_index and position width
    localparam int DATA_W          = 32;   // table entry and key width
    localparam int DEF_TABLE_DEPTH = 1024;

    // Input word modes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;    // write the input word's entry into the table
        logic start;      // latch the key and open the full search range
        logic rd_en;      // read the midpoint entry and remember the midpoint
        logic cmp_upd;    // narrow the range after a mismatch
        logic res_ld;     // load the result register
        logic res_found;  // found flag to load with the result
    } t_bse_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;      // the search range holds no entry
        logic match;      // the entry just read equals the key
    } t_bse_sts;

endpackage
`default_nettype wire

>>> rtl/bse_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary search engine datapath
// Table memory, length register, search range registers, probe compare and
// the result register.
// ----------------------------------------------------------------------------
module bse_dpath import bse_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [LEN_W-1:0]         i_cfg_wdata,
    input  wire logic [IDX_W-1:0]         i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_entry_value,
    input  wire logic signed [DATA_W-1:0] i_search_key,
    input  wire t_bse_cmd                 i_cmd,
    output t_bse_sts                      o_sts,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_position
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int LW   = (CW > LEN_W) ? CW : LEN_W;
    localparam int XW   = (IDX_W > CW) ? IDX_W + 1 : CW + 1;

    logic signed [DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_key;
    logic [LEN_W-1:0]         r_table_length;
    logic [CW-1:0]            r_lo;
    logic [CW-1:0]            r_hi_ex;      // one past the last index in range
    logic [AW-1:0]            r_mid;

    logic [CW-1:0]            len_sat;
    logic [CW:0]              mid_sum;
    logic [AW-1:0]            mid_c;
    logic                     idx_ok;

    // Lengths beyond the table saturate to the table depth.
    always_comb begin
        if (LW'(r_table_length) > LW'(TABLE_DEPTH)) begin
            len_sat = CW'(TABLE_DEPTH);
        end else begin
            len_sat = CW'(r_table_length);
        end
    end

    // Midpoint of [lo, hi_ex-1]; only used while the range is not empty.
    assign mid_sum = (CW+1)'(r_lo) + (CW+1)'(r_hi_ex) - (CW+1)'(1);
    assign mid_c   = AW'(mid_sum >> 1);

    assign idx_ok  = XW'(i_entry_index) < XW'(TABLE_DEPTH);

    assign o_sts.empty = (r_lo >= r_hi_ex);
    assign o_sts.match = (r_rd_data == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (i_cfg_we) begin
            r_table_length <= i_cfg_wdata;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && idx_ok) begin
            r_mem[AW'(i_entry_index)] <= i_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[mid_c];
            r_mid     <= mid_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key   <= i_search_key;
            r_lo    <= '0;
            r_hi_ex <= len_sat;
        end else if (i_cmd.cmp_upd) begin
            if (r_rd_data > r_key) begin
                r_hi_ex <= CW'(r_mid);
            end else begin
                r_lo <= CW'((CW+1)'(r_mid) + (CW+1)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            o_found    <= i_cmd.res_found;
            o_position <= i_cmd.res_found ? IDX_W'(r_mid) : '0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary search engine controller
// Sequences loads, the read and compare steps of each probe, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module bse_ctrl import bse_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_mode,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_bse_sts i_sts,
    output t_bse_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_hit, n_hit;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        o_cmd   = '0;
        o_cmd.res_found = r_hit;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (i_sts.empty) begin
                    n_hit   = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.match) begin
                    n_hit   = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.cmp_upd = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_ld) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // A loaded result is presented on the next cycle.
    a_res_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_ld |=> r_out_valid)
        else $error("result load did not raise output valid");

    // A pending, stalled result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.res_ld)
        else $error("stalled result overwritten");

    // The table is only probed inside a non-empty range.
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> !i_sts.empty)
        else $error("probe issued on an empty range");

    // An accepted search word always starts with a range check.
    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode != MODE_LOAD) |=> (r_state == ST_READ))
        else $error("search did not start");

endmodule
`default_nettype wire

>>> rtl/binary_search_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Binary search engine
// Sorted table of signed 32-bit entries with a classic binary search over
// the first table_length entries.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Word
//  -------  ---------  -------------------------  -------------------------------
//  in       input      i_in_valid / o_in_stall    mode, entry_index, entry_value,
//                                                 search_key
//  out      output     o_out_valid / i_out_stall  found, position
//  cfg      input      i_cfg_we                   table_length
//
//  A load word writes one table entry and gives no result; the engine stays
//  idle. A search word makes at most 11 probes for 1024 entries: each probe
//  reads the table memory through its registered read port and then
//  compares; a hit ends at the compare, a miss ends when the range is found
//  empty, and the output register is then loaded before the next word is
//  accepted.
//  Reset (synchronous, active low) clears the controller and table_length;
//  table contents are undefined until written.
//  While a search runs the input channel is stalled. A finished result waits
//  in the output register, and a new word is accepted meanwhile; a search
//  that ends while that register is still stalled waits before loading it.
//
module binary_search_engine import bse_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Configuration write port.
    input  wire logic                     i_cfg_we,
    input  wire logic [LEN_W-1:0]         i_cfg_wdata,
    // Input channel.
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic                     i_mode,
    input  wire logic [IDX_W-1:0]         i_entry_index,
    input  wire logic signed [DATA_W-1:0] i_entry_value,
    input  wire logic signed [DATA_W-1:0] i_search_key,
    // Output channel.
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_position
);

    t_bse_cmd cmd;
    t_bse_sts sts;

    // The controller decides every step; the datapath only acts on commands.
    bse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the table, the range registers and the result word.
    bse_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule
`default_nettype wire
